// File: hw/rtl/tsd_pkg.sv
// Shared types and codes for the token scanner automaton.
`default_nettype none

package tsd_pkg;

	localparam int unsigned StateW = 5;
	localparam int unsigned KindW  = 2;
	localparam int unsigned ClassW = 3;

	// Automaton states
	localparam logic [StateW-1:0] ST_START    = 5'd0;
	localparam logic [StateW-1:0] ST_IDENT    = 5'd1;
	localparam logic [StateW-1:0] ST_INT      = 5'd2;
	localparam logic [StateW-1:0] ST_DEC      = 5'd3;
	localparam logic [StateW-1:0] ST_STAR     = 5'd4;
	localparam logic [StateW-1:0] ST_POW      = 5'd5;
	localparam logic [StateW-1:0] ST_SLASH    = 5'd6;
	localparam logic [StateW-1:0] ST_MINUS    = 5'd7;
	localparam logic [StateW-1:0] ST_PLUS     = 5'd8;
	localparam logic [StateW-1:0] ST_COMMA    = 5'd9;
	localparam logic [StateW-1:0] ST_SEMI     = 5'd10;
	localparam logic [StateW-1:0] ST_LPAREN   = 5'd11;
	localparam logic [StateW-1:0] ST_RPAREN   = 5'd12;
	localparam logic [StateW-1:0] ST_COMMENT  = 5'd13;
	localparam logic [StateW-1:0] ST_EXP      = 5'd14;
	localparam logic [StateW-1:0] ST_EXP_SIGN = 5'd15;
	localparam logic [StateW-1:0] ST_EXP_DIG  = 5'd16;

	// State kinds
	localparam logic [KindW-1:0] KIND_START  = 2'd0;
	localparam logic [KindW-1:0] KIND_ACCEPT = 2'd1;
	localparam logic [KindW-1:0] KIND_INTER  = 2'd2;

	// Token classes
	localparam logic [ClassW-1:0] CLS_NONE     = 3'd0;
	localparam logic [ClassW-1:0] CLS_IDENT    = 3'd1;
	localparam logic [ClassW-1:0] CLS_LITERAL  = 3'd2;
	localparam logic [ClassW-1:0] CLS_OPERATOR = 3'd3;
	localparam logic [ClassW-1:0] CLS_PUNCT    = 3'd4;
	localparam logic [ClassW-1:0] CLS_COMMENT  = 3'd5;

	// Character constants
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_LOW_E      = 8'h65;
	localparam logic [7:0] CH_UP_E       = 8'h45;
	localparam logic [7:0] CH_STAR       = 8'h2A;
	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_PLUS       = 8'h2B;
	localparam logic [7:0] CH_MINUS      = 8'h2D;
	localparam logic [7:0] CH_COMMA      = 8'h2C;
	localparam logic [7:0] CH_SEMI       = 8'h3B;
	localparam logic [7:0] CH_LPAREN     = 8'h28;
	localparam logic [7:0] CH_RPAREN     = 8'h29;

	// Outcome of one character step
	typedef struct packed {
		logic              took;
		logic [StateW-1:0] state;
		logic [KindW-1:0]  kind;
		logic [ClassW-1:0] cls;
	} tsd_step_t;

endpackage

`default_nettype wire

// File: hw/rtl/tsd_next.sv
// Next-state and state classification logic of the token scanner automaton.
`default_nettype none

module tsd_next (
	input  logic [tsd_pkg::StateW-1:0] state,
	input  logic [7:0]                 char_in,
	input  logic                       start_token,
	output tsd_pkg::tsd_step_t         step
);
	import tsd_pkg::*;

	logic              is_letter;
	logic              is_digit;
	logic              is_e;
	logic [StateW-1:0] base;
	logic [StateW-1:0] nx;
	logic              move;
	logic [StateW-1:0] fin;
	logic [ClassW-1:0] cls;

	// Classify the character
	assign is_letter = (char_in >= 8'h61 && char_in <= 8'h7A)
		|| (char_in >= 8'h41 && char_in <= 8'h5A) || char_in == CH_UNDERSCORE;
	assign is_digit  = char_in >= 8'h30 && char_in <= 8'h39;
	assign is_e      = char_in == CH_LOW_E || char_in == CH_UP_E;

	// Restart at the start state when a new token begins
	assign base = start_token ? ST_START : state;

	// Decode the transition
	always_comb begin
		nx   = base;
		move = 1'b1;
		unique case (base)
			ST_START: begin
				if (is_letter)                 nx = ST_IDENT;
				else if (is_digit)             nx = ST_INT;
				else if (char_in == CH_STAR)   nx = ST_STAR;
				else if (char_in == CH_SLASH)  nx = ST_SLASH;
				else if (char_in == CH_PLUS)   nx = ST_PLUS;
				else if (char_in == CH_MINUS)  nx = ST_MINUS;
				else if (char_in == CH_COMMA)  nx = ST_COMMA;
				else if (char_in == CH_SEMI)   nx = ST_SEMI;
				else if (char_in == CH_LPAREN) nx = ST_LPAREN;
				else if (char_in == CH_RPAREN) nx = ST_RPAREN;
				else                           move = 1'b0;
			end
			ST_IDENT: begin
				if (is_letter || is_digit) nx = ST_IDENT;
				else                       move = 1'b0;
			end
			ST_INT: begin
				if (char_in == CH_DOT) nx = ST_DEC;
				else if (is_digit)     nx = ST_INT;
				else if (is_e)         nx = ST_EXP;
				else                   move = 1'b0;
			end
			ST_DEC: begin
				if (is_digit)  nx = ST_DEC;
				else if (is_e) nx = ST_EXP;
				else           move = 1'b0;
			end
			ST_STAR: begin
				if (char_in == CH_STAR) nx = ST_POW;
				else                    move = 1'b0;
			end
			ST_SLASH: begin
				if (char_in == CH_SLASH) nx = ST_COMMENT;
				else                     move = 1'b0;
			end
			ST_MINUS: begin
				if (char_in == CH_MINUS) nx = ST_COMMENT;
				else                     move = 1'b0;
			end
			ST_EXP: begin
				if (char_in == CH_PLUS || char_in == CH_MINUS) nx = ST_EXP_SIGN;
				else if (is_digit)                             nx = ST_EXP_DIG;
				else                                           move = 1'b0;
			end
			ST_EXP_SIGN, ST_EXP_DIG: begin
				if (is_digit) nx = ST_EXP_DIG;
				else          move = 1'b0;
			end
			default: begin
				move = 1'b0;
			end
		endcase
	end

	assign fin = move ? nx : base;

	// Map the resulting state to its token class
	always_comb begin
		case (fin)
			ST_IDENT:                        cls = CLS_IDENT;
			ST_INT, ST_DEC, ST_EXP_DIG:      cls = CLS_LITERAL;
			ST_STAR, ST_POW, ST_SLASH,
			ST_MINUS, ST_PLUS:               cls = CLS_OPERATOR;
			ST_COMMA, ST_SEMI, ST_LPAREN,
			ST_RPAREN:                       cls = CLS_PUNCT;
			ST_COMMENT:                      cls = CLS_COMMENT;
			default:                         cls = CLS_NONE;
		endcase
	end

	assign step.took  = move;
	assign step.state = fin;
	assign step.cls   = cls;
	assign step.kind  = (fin == ST_START) ? KIND_START
		: (cls != CLS_NONE) ? KIND_ACCEPT : KIND_INTER;

endmodule

`default_nettype wire

// File: hw/rtl/token_scanner_dfa_core.sv
// Token scanner automaton core: input register, step logic and result register.
// Each word carries one character and a start-of-token flag; the core reports
// whether the automaton moved, the state after the character, its kind and its
// token class. One word is taken per cycle while the output is not stalled: a
// word is held in the input register, the state update and the result are
// computed from it combinationally, and the result is captured in the output
// register when the output register is free. A stalled result holds the input
// register, and the input stalls only while both registers are full and the
// output is stalled. The state register is the only feedback path, so the rate
// is set by one pass through the character decode and state case.
`default_nettype none

module token_scanner_dfa_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  char_in,
	input  logic                        start_token,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        took_step,
	output logic [tsd_pkg::StateW-1:0]  dfa_state,
	output logic [tsd_pkg::KindW-1:0]   state_kind,
	output logic [tsd_pkg::ClassW-1:0]  token_class
);
	import tsd_pkg::*;

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              start_s1;
	logic [StateW-1:0] state_q;
	logic              out_valid_q;
	tsd_step_t         res_q;
	tsd_step_t         step;
	logic              advance;

	// Move the input word on when the result register is free
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// Hold the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if ((advance || !valid_s1) && in_valid) begin
			char_s1  <= char_in;
			start_s1 <= start_token;
		end
	end

	tsd_next u_next (
		.state       (state_q),
		.char_in     (char_s1),
		.start_token (start_s1),
		.step        (step)
	);

	// Advance the automaton state and the result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_START;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= step.state;
			end
		end
	end

	// Capture the result word
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= step;
		end
	end

	assign out_valid   = out_valid_q;
	assign took_step   = res_q.took;
	assign dfa_state   = res_q.state;
	assign state_kind  = res_q.kind;
	assign token_class = res_q.cls;

endmodule

`default_nettype wire

// File: dv/token_scanner_dfa_core_tb.sv
// Self-checking testbench for the token scanner automaton core.
module token_scanner_dfa_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tsd_pkg::*;

	localparam int unsigned RandomWords = 1450;
	localparam int unsigned CycleLimit  = 400000;
	localparam int unsigned TailCycles  = 16;

	localparam logic [7:0] CH_ZERO = "0";
	localparam logic [7:0] CH_NINE = "9";
	localparam logic [7:0] CH_LOW_A = "a";
	localparam logic [7:0] CH_LOW_Z = "z";
	localparam logic [7:0] CH_UP_A = "A";
	localparam logic [7:0] CH_UP_Z = "Z";

	typedef enum int {
		TOK_IDENT, TOK_INTEGER, TOK_DECIMAL, TOK_EXPONENT,
		TOK_OPERATOR, TOK_PUNCT, TOK_COMMENT
	} tok_shape_e;

	// Tracks the automaton state and holds the steps still owed by the core
	class token_step_tracker;
		logic [StateW-1:0] scan_state;
		tsd_step_t         owed_steps[$];
		int unsigned       errors;
		int unsigned       words_seen;
		int unsigned       steps_checked;
		int unsigned       moves;
		logic [16:0]       states_hit;

		function new();
			scan_state    = ST_START;
			errors        = 0;
			words_seen    = 0;
			steps_checked = 0;
			moves         = 0;
			states_hit    = '0;
		endfunction

		function bit is_letter(logic [7:0] c);
			return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z)
				|| c == CH_UNDERSCORE;
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= CH_ZERO && c <= CH_NINE;
		endfunction

		// Follow one character from a state; flag whether a transition exists
		function logic [StateW-1:0] follow(logic [StateW-1:0] st, logic [7:0] c,
				output bit moved);
			logic [StateW-1:0] nx;
			nx    = st;
			moved = 1'b1;
			case (st)
				ST_START: begin
					if (is_letter(c)) nx = ST_IDENT;
					else if (is_digit(c)) nx = ST_INT;
					else if (c == CH_STAR) nx = ST_STAR;
					else if (c == CH_SLASH) nx = ST_SLASH;
					else if (c == CH_PLUS) nx = ST_PLUS;
					else if (c == CH_MINUS) nx = ST_MINUS;
					else if (c == CH_COMMA) nx = ST_COMMA;
					else if (c == CH_SEMI) nx = ST_SEMI;
					else if (c == CH_LPAREN) nx = ST_LPAREN;
					else if (c == CH_RPAREN) nx = ST_RPAREN;
					else moved = 1'b0;
				end
				ST_IDENT: begin
					if (is_letter(c) || is_digit(c)) nx = ST_IDENT;
					else moved = 1'b0;
				end
				ST_INT: begin
					if (c == CH_DOT) nx = ST_DEC;
					else if (is_digit(c)) nx = ST_INT;
					else if (c == CH_LOW_E || c == CH_UP_E) nx = ST_EXP;
					else moved = 1'b0;
				end
				ST_DEC: begin
					if (is_digit(c)) nx = ST_DEC;
					else if (c == CH_LOW_E || c == CH_UP_E) nx = ST_EXP;
					else moved = 1'b0;
				end
				ST_STAR: begin
					if (c == CH_STAR) nx = ST_POW;
					else moved = 1'b0;
				end
				ST_SLASH: begin
					if (c == CH_SLASH) nx = ST_COMMENT;
					else moved = 1'b0;
				end
				ST_MINUS: begin
					if (c == CH_MINUS) nx = ST_COMMENT;
					else moved = 1'b0;
				end
				ST_EXP: begin
					if (c == CH_PLUS || c == CH_MINUS) nx = ST_EXP_SIGN;
					else if (is_digit(c)) nx = ST_EXP_DIG;
					else moved = 1'b0;
				end
				ST_EXP_SIGN, ST_EXP_DIG: begin
					if (is_digit(c)) nx = ST_EXP_DIG;
					else moved = 1'b0;
				end
				default: moved = 1'b0;
			endcase
			return nx;
		endfunction

		function logic [ClassW-1:0] class_for(logic [StateW-1:0] st);
			case (st)
				ST_IDENT: return CLS_IDENT;
				ST_INT, ST_DEC, ST_EXP_DIG: return CLS_LITERAL;
				ST_STAR, ST_POW, ST_SLASH, ST_MINUS, ST_PLUS: return CLS_OPERATOR;
				ST_COMMA, ST_SEMI, ST_LPAREN, ST_RPAREN: return CLS_PUNCT;
				ST_COMMENT: return CLS_COMMENT;
				default: return CLS_NONE;
			endcase
		endfunction

		// Advance the predicted state on an accepted word and queue its step
		function void note_word(logic [7:0] c, logic start);
			tsd_step_t         step;
			logic [StateW-1:0] st;
			logic [StateW-1:0] nx;
			bit                moved;
			st = start ? ST_START : scan_state;
			nx = follow(st, c, moved);
			if (moved) begin
				st = nx;
				moves++;
			end
			scan_state = st;
			step.took  = moved;
			step.state = st;
			step.cls   = class_for(st);
			if (st == ST_START) step.kind = KIND_START;
			else if (step.cls != CLS_NONE) step.kind = KIND_ACCEPT;
			else step.kind = KIND_INTER;
			if (st <= ST_EXP_DIG) states_hit[st] = 1'b1;
			owed_steps.push_back(step);
			words_seen++;
		endfunction

		// Compare one delivered step against the oldest owed one
		function void check_result(logic took, logic [StateW-1:0] st,
				logic [KindW-1:0] kind, logic [ClassW-1:0] cls);
			tsd_step_t want;
			if (owed_steps.size() == 0) begin
				$display("%0t: unexpected result took=%0d state=%0d kind=%0d class=%0d",
					$time, took, st, kind, cls);
				errors++;
				return;
			end
			want = owed_steps.pop_front();
			steps_checked++;
			if (took !== want.took) begin
				$display("%0t: took_step expected %0d got %0d", $time, want.took, took);
				errors++;
			end
			if (st !== want.state) begin
				$display("%0t: dfa_state expected %0d got %0d", $time, want.state, st);
				errors++;
			end
			if (kind !== want.kind) begin
				$display("%0t: state_kind expected %0d got %0d", $time, want.kind, kind);
				errors++;
			end
			if (cls !== want.cls) begin
				$display("%0t: token_class expected %0d got %0d", $time, want.cls, cls);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return owed_steps.size();
		endfunction
	endclass

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_stall;
	logic [7:0]          char_in     = 8'h00;
	logic                start_token = 1'b0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	logic                took_step;
	logic [StateW-1:0]   dfa_state;
	logic [KindW-1:0]    state_kind;
	logic [ClassW-1:0]   token_class;

	token_step_tracker   tracker = new();
	int unsigned         cycle_count = 0;
	int unsigned         words_sent  = 0;
	int unsigned         burst_left  = 1;
	int unsigned         stall_mode  = 0;
	int unsigned         stall_left  = 0;
	int unsigned         mode_timer  = 0;

	token_scanner_dfa_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_in     (char_in),
		.start_token (start_token),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.took_step   (took_step),
		.dfa_state   (dfa_state),
		.state_kind  (state_kind),
		.token_class (token_class)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// Record accepted words and check delivered results
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) tracker.note_word(char_in, start_token);
			if (out_valid && !out_stall)
				tracker.check_result(took_step, dfa_state, state_kind, token_class);
		end
	end

	// Stall the result side on a shifting pattern
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else begin
			case (stall_mode)
				0: out_stall = 1'b0;
				1: out_stall = ($urandom_range(0, 2) == 0);
				2: begin
					out_stall = ($urandom_range(0, 9) == 0);
					if (out_stall) stall_left = $urandom_range(1, 7);
				end
				default: out_stall = ~out_stall;
			endcase
		end
		if (mode_timer == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_timer = $urandom_range(50, 300);
		end else begin
			mode_timer--;
		end
	end

	// Offer one word, hold it until taken, then idle at burst ends
	task automatic emit(input logic [7:0] c, input logic s);
		int unsigned gap;
		in_valid    = 1'b1;
		char_in     = c;
		start_token = s;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		words_sent++;
		burst_left--;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
	endtask

	// Hold off the sender until every owed result has come back
	task automatic drain();
		in_valid = 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] pick_letter();
		int unsigned r;
		r = $urandom_range(0, 52);
		if (r < 26) return CH_LOW_A + 8'(r);
		if (r < 52) return CH_UP_A + 8'(r - 26);
		return CH_UNDERSCORE;
	endfunction

	function automatic logic [7:0] pick_alnum();
		return ($urandom_range(0, 3) == 0) ? pick_digit() : pick_letter();
	endfunction

	// Send a digit run, first digit opening the token when asked
	task automatic emit_digits(input bit opens, input int unsigned n);
		for (int unsigned i = 0; i < n; i++) emit(pick_digit(), opens && i == 0);
	endtask

	// Send one well-formed token with random content
	task automatic emit_token();
		tok_shape_e  shape;
		int unsigned r;
		shape = tok_shape_e'($urandom_range(0, 6));
		case (shape)
			TOK_IDENT: begin
				emit(pick_letter(), 1'b1);
				repeat ($urandom_range(0, 6)) emit(pick_alnum(), 1'b0);
			end
			TOK_INTEGER: emit_digits(1'b1, $urandom_range(1, 5));
			TOK_DECIMAL: begin
				emit_digits(1'b1, $urandom_range(1, 3));
				emit(CH_DOT, 1'b0);
				emit_digits(1'b0, $urandom_range(0, 3));
			end
			TOK_EXPONENT: begin
				emit_digits(1'b1, $urandom_range(1, 3));
				if ($urandom_range(0, 1)) begin
					emit(CH_DOT, 1'b0);
					emit_digits(1'b0, $urandom_range(0, 2));
				end
				emit($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E, 1'b0);
				r = $urandom_range(0, 2);
				if (r == 1) emit(CH_PLUS, 1'b0);
				else if (r == 2) emit(CH_MINUS, 1'b0);
				emit_digits(1'b0, $urandom_range(1, 3));
			end
			TOK_OPERATOR: begin
				r = $urandom_range(0, 4);
				case (r)
					0: emit(CH_STAR, 1'b1);
					1: begin emit(CH_STAR, 1'b1); emit(CH_STAR, 1'b0); end
					2: emit(CH_SLASH, 1'b1);
					3: emit(CH_MINUS, 1'b1);
					default: emit(CH_PLUS, 1'b1);
				endcase
			end
			TOK_PUNCT: begin
				r = $urandom_range(0, 3);
				case (r)
					0: emit(CH_COMMA, 1'b1);
					1: emit(CH_SEMI, 1'b1);
					2: emit(CH_LPAREN, 1'b1);
					default: emit(CH_RPAREN, 1'b1);
				endcase
			end
			default: begin
				if ($urandom_range(0, 1)) begin
					emit(CH_SLASH, 1'b1);
					emit(CH_SLASH, 1'b0);
				end else begin
					emit(CH_MINUS, 1'b1);
					emit(CH_MINUS, 1'b0);
				end
				repeat ($urandom_range(0, 4)) emit(8'($urandom_range(32, 126)), 1'b0);
			end
		endcase
		// Sometimes run a stray character into the token
		if ($urandom_range(0, 9) < 3) emit(8'($urandom_range(0, 127)), 1'b0);
	endtask

	// Break a literal partway and push an arbitrary character at it
	task automatic emit_broken();
		emit_digits(1'b1, $urandom_range(1, 2));
		if ($urandom_range(0, 1)) emit(CH_DOT, 1'b0);
		if ($urandom_range(0, 1)) emit(CH_UP_E, 1'b0);
		if ($urandom_range(0, 1)) emit(CH_MINUS, 1'b0);
		emit(8'($urandom_range(0, 255)), 1'b0);
	endtask

	initial begin
		int unsigned r;
		int unsigned random_goal;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extreme codes, every token shape, dead ends and high codes
		emit(8'h00, 1'b1);
		emit(8'hFF, 1'b0);
		emit(CH_UNDERSCORE, 1'b1);
		emit(CH_UP_Z, 1'b0);
		emit(CH_NINE, 1'b0);
		emit(8'h80, 1'b0);
		emit("1", 1'b1);
		emit(CH_DOT, 1'b0);
		emit("5", 1'b0);
		emit(CH_LOW_E, 1'b0);
		emit(CH_MINUS, 1'b0);
		emit("7", 1'b0);
		emit(CH_STAR, 1'b1);
		emit(CH_STAR, 1'b0);
		emit(CH_STAR, 1'b0);
		emit(CH_SLASH, 1'b1);
		emit(CH_SLASH, 1'b0);
		emit(CH_MINUS, 1'b1);
		emit(CH_MINUS, 1'b0);
		emit(CH_PLUS, 1'b1);
		emit(CH_COMMA, 1'b1);
		emit(CH_SEMI, 1'b1);
		emit(CH_LPAREN, 1'b1);
		emit(CH_RPAREN, 1'b0);
		emit(CH_RPAREN, 1'b1);
		drain();

		// Random: mostly well-formed tokens, some noise and broken literals
		random_goal = words_sent + RandomWords;
		while (words_sent < random_goal) begin
			r = $urandom_range(0, 99);
			if (r < 78) emit_token();
			else if (r < 92) emit(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			else emit_broken();
			if (words_sent > random_goal - RandomWords / 2 && tracker.moves % 97 == 0)
				drain();
		end

		drain();
		repeat (TailCycles) @(posedge clk);

		$display("Covered %0d words, %0d checked results, %0d moves, %0d rejects.",
			tracker.words_seen, tracker.steps_checked, tracker.moves,
			tracker.words_seen - tracker.moves);
		$display("States reached (bit per state): %b", tracker.states_hit);
		if (tracker.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
